// ===== rtl/hcc_pkg.sv =====
// types, constants and register codes shared by the colour key and centroid blocks
package hcc_pkg;

  localparam int unsigned HUE_W    = 8;
  localparam int unsigned SAT_W    = 8;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned CNT_W    = 21;
  localparam int unsigned PROD_W   = WEIGHT_W + COORD_W;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QAW      = $clog2(QDEPTH);

  localparam logic [COORD_W-1:0]  COORD_MAX      = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 9'd256;
  localparam logic [HUE_W-1:0]    HUE_LOW_RST    = 8'd180;
  localparam logic [HUE_W-1:0]    HUE_HIGH_RST   = 8'd180;
  localparam logic [SAT_W-1:0]    SAT_THR_RST    = 8'd127;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 9'd0;

  typedef enum logic [1:0] {
    CFG_HUE_LOW  = 2'd0,
    CFG_HUE_HIGH = 2'd1,
    CFG_SAT_THR  = 2'd2,
    CFG_WEIGHT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DIV,
    BK_MUL,
    BK_SUM
  } back_state_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_low;
    logic [HUE_W-1:0] hue_high;
    logic [SAT_W-1:0] sat_threshold;
  } key_cfg_t;

  typedef struct packed {
    logic               keyed;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } pix_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/hcc_ifs.sv =====
// valid/ready channel interfaces for the pixel input and the result output
interface hcc_pix_if;
  logic                         valid;
  logic                         ready;
  logic [hcc_pkg::HUE_W-1:0]    hue;
  logic [hcc_pkg::SAT_W-1:0]    saturation;
  logic [hcc_pkg::COORD_W-1:0]  col;
  logic [hcc_pkg::COORD_W-1:0]  row;
  logic                         frame_last;

  modport source (output valid, hue, saturation, col, row, frame_last, input ready);
  modport sink   (input valid, hue, saturation, col, row, frame_last, output ready);
endinterface

interface hcc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         mask_on;
  logic [hcc_pkg::COORD_W-1:0]  center_col;
  logic [hcc_pkg::COORD_W-1:0]  center_row;
  logic                         frame_done;

  modport source (output valid, mask_on, center_col, center_row, frame_done, input ready);
  modport sink   (input valid, mask_on, center_col, center_row, frame_done, output ready);
endinterface

// ===== rtl/hcc_front.sv =====
// front end: keys each pixel on hue and saturation and clamps its coordinates
module hcc_front #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  hcc_pix_if.sink             pix,
  input  hcc_pkg::key_cfg_t   cfg,
  input  logic                q_ready,
  output logic                q_push,
  output hcc_pkg::pix_t       q_data
);

  localparam int unsigned LIM_W = 13;
  localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(MAX_COLS);
  localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(MAX_ROWS);
  localparam logic [hcc_pkg::COORD_W-1:0] COL_TOP = hcc_pkg::COORD_W'(MAX_COLS - 1);
  localparam logic [hcc_pkg::COORD_W-1:0] ROW_TOP = hcc_pkg::COORD_W'(MAX_ROWS - 1);

  logic sat_ok;
  logic hue_ok;
  logic hue_ge_low;
  logic hue_le_high;

  assign pix.ready = q_ready;
  assign q_push    = pix.valid & q_ready;

  always_comb begin
    sat_ok      = pix.saturation > cfg.sat_threshold;
    hue_ge_low  = pix.hue >= cfg.hue_low;
    hue_le_high = pix.hue <= cfg.hue_high;
    // window wraps round unless the low bound is below the high bound
    if (cfg.hue_low < cfg.hue_high) begin
      hue_ok = hue_ge_low & hue_le_high;
    end else begin
      hue_ok = hue_ge_low | hue_le_high;
    end
    q_data.keyed = sat_ok & hue_ok;
    q_data.col   = ({3'b000, pix.col} >= COL_LIM) ? COL_TOP : pix.col;
    q_data.row   = ({3'b000, pix.row} >= ROW_LIM) ? ROW_TOP : pix.row;
    q_data.last  = pix.frame_last;
  end

endmodule

// ===== rtl/hcc_fifo.sv =====
// short queue of classified pixels between front and back end
module hcc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcc_pkg::pix_t  push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output hcc_pkg::pix_t  pop_data
);

  hcc_pkg::pix_t            mem [hcc_pkg::QDEPTH];
  logic [hcc_pkg::QAW-1:0]  wr_ptr;
  logic [hcc_pkg::QAW-1:0]  rd_ptr;
  logic [hcc_pkg::QAW:0]    fill;

  assign push_ready = fill != (hcc_pkg::QAW+1)'(hcc_pkg::QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/hcc_div.sv =====
// restoring divider, one quotient bit per cycle
module hcc_div (
  input  logic               clk,
  input  logic               rst,
  input  hcc_pkg::div_req_t  req,
  output hcc_pkg::div_rsp_t  rsp
);

  logic                          busy;
  logic                          done;
  logic [hcc_pkg::STEP_W-1:0]    step;
  logic [hcc_pkg::CNT_W-1:0]     rem;
  logic [hcc_pkg::CNT_W-1:0]     rem_next;
  logic [hcc_pkg::SUM_W-1:0]     dvd;
  logic [hcc_pkg::CNT_W-1:0]     dvs;
  logic [hcc_pkg::CNT_W:0]       trial;
  logic                          ge;

  always_comb begin
    trial    = {rem, dvd[hcc_pkg::SUM_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? hcc_pkg::CNT_W'(trial - {1'b0, dvs}) : trial[hcc_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == hcc_pkg::STEP_W'(hcc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[hcc_pkg::SUM_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// ===== rtl/hcc_back.sv =====
// back end: accumulates keyed coordinates, blends the frame centroid, drives results
module hcc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  hcc_pkg::pix_t                   q_data,
  output logic                            q_pop,
  input  logic [hcc_pkg::WEIGHT_W-1:0]    smooth_weight,
  hcc_res_if.source                       res
);

  localparam int unsigned RND_W = hcc_pkg::PROD_W - 8;

  hcc_pkg::back_state_t state;
  hcc_pkg::back_state_t state_next;

  logic [hcc_pkg::SUM_W-1:0]    sum_col;
  logic [hcc_pkg::SUM_W-1:0]    sum_row;
  logic [hcc_pkg::CNT_W-1:0]    keyed_count;
  logic [hcc_pkg::SUM_W-1:0]    sum_col_fin;
  logic [hcc_pkg::SUM_W-1:0]    sum_row_fin;
  logic [hcc_pkg::CNT_W-1:0]    cnt_fin;
  logic [hcc_pkg::COORD_W-1:0]  center_col;
  logic [hcc_pkg::COORD_W-1:0]  center_row;
  logic                         pend_keyed;

  logic                         out_valid;
  logic                         out_mask;
  logic [hcc_pkg::COORD_W-1:0]  out_col;
  logic [hcc_pkg::COORD_W-1:0]  out_row;
  logic                         out_done;
  logic                         out_free;

  logic                         div_start;
  logic                         load_run;
  logic                         load_sum;

  hcc_pkg::div_req_t            div_col_req;
  hcc_pkg::div_req_t            div_row_req;
  hcc_pkg::div_rsp_t            div_col_rsp;
  hcc_pkg::div_rsp_t            div_row_rsp;

  logic [hcc_pkg::WEIGHT_W-1:0] w_sat;
  logic [hcc_pkg::WEIGHT_W-1:0] w_inv;
  logic [hcc_pkg::COORD_W-1:0]  mean_col;
  logic [hcc_pkg::COORD_W-1:0]  mean_row;
  logic [hcc_pkg::PROD_W-1:0]   keep_col_p;
  logic [hcc_pkg::PROD_W-1:0]   keep_row_p;
  logic [hcc_pkg::PROD_W-1:0]   new_col_p;
  logic [hcc_pkg::PROD_W-1:0]   new_row_p;
  logic [RND_W:0]               blend_col;
  logic [RND_W:0]               blend_row;
  logic [hcc_pkg::COORD_W-1:0]  center_col_next;
  logic [hcc_pkg::COORD_W-1:0]  center_row_next;

  // divide a product by 256, rounding to nearest with ties to even
  function automatic logic [RND_W-1:0] rne_div256(input logic [hcc_pkg::PROD_W-1:0] n);
    logic [RND_W-1:0] q;
    logic [7:0]       r;
    q = n[hcc_pkg::PROD_W-1:8];
    r = n[7:0];
    if (r > 8'd128 || (r == 8'd128 && q[0])) begin
      q = q + 1'b1;
    end
    return q;
  endfunction

  function automatic logic [hcc_pkg::COORD_W-1:0] sat_mean(input logic [hcc_pkg::SUM_W-1:0] q);
    return (|q[hcc_pkg::SUM_W-1:hcc_pkg::COORD_W]) ? hcc_pkg::COORD_MAX
                                                   : q[hcc_pkg::COORD_W-1:0];
  endfunction

  // totals including the pixel at the queue head
  always_comb begin
    sum_col_fin = sum_col + (q_data.keyed ? hcc_pkg::SUM_W'(q_data.col) : '0);
    sum_row_fin = sum_row + (q_data.keyed ? hcc_pkg::SUM_W'(q_data.row) : '0);
    cnt_fin     = keyed_count + hcc_pkg::CNT_W'(q_data.keyed);
  end

  assign out_free = !out_valid || res.ready;

  always_comb begin
    state_next = state;
    case (state)
      hcc_pkg::BK_RUN: begin
        if (div_start) begin
          state_next = hcc_pkg::BK_DIV;
        end
      end
      hcc_pkg::BK_DIV: begin
        if (div_col_rsp.done && div_row_rsp.done) begin
          state_next = hcc_pkg::BK_MUL;
        end
      end
      hcc_pkg::BK_MUL: state_next = hcc_pkg::BK_SUM;
      hcc_pkg::BK_SUM: state_next = hcc_pkg::BK_RUN;
      default:         state_next = hcc_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_run  = 1'b0;
    load_sum  = 1'b0;
    case (state)
      hcc_pkg::BK_RUN: begin
        q_pop     = q_valid && out_free;
        div_start = q_pop && q_data.last && (cnt_fin != '0);
        load_run  = q_pop && !div_start;
      end
      hcc_pkg::BK_SUM: load_sum = 1'b1;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_col_req.start    = div_start;
    div_col_req.dividend = sum_col_fin;
    div_col_req.divisor  = cnt_fin;
    div_row_req.start    = div_start;
    div_row_req.dividend = sum_row_fin;
    div_row_req.divisor  = cnt_fin;
  end

  hcc_div u_div_col (
    .clk (clk),
    .rst (rst),
    .req (div_col_req),
    .rsp (div_col_rsp)
  );

  hcc_div u_div_row (
    .clk (clk),
    .rst (rst),
    .req (div_row_req),
    .rsp (div_row_rsp)
  );

  always_comb begin
    w_sat    = (smooth_weight > hcc_pkg::WEIGHT_ONE) ? hcc_pkg::WEIGHT_ONE : smooth_weight;
    w_inv    = hcc_pkg::WEIGHT_ONE - w_sat;
    mean_col = sat_mean(div_col_rsp.quotient);
    mean_row = sat_mean(div_row_rsp.quotient);
  end

  always_ff @(posedge clk) begin
    if (state == hcc_pkg::BK_MUL) begin
      keep_col_p <= hcc_pkg::PROD_W'(w_inv) * hcc_pkg::PROD_W'(center_col);
      keep_row_p <= hcc_pkg::PROD_W'(w_inv) * hcc_pkg::PROD_W'(center_row);
      new_col_p  <= hcc_pkg::PROD_W'(w_sat) * hcc_pkg::PROD_W'(mean_col);
      new_row_p  <= hcc_pkg::PROD_W'(w_sat) * hcc_pkg::PROD_W'(mean_row);
    end
  end

  always_comb begin
    blend_col = {1'b0, rne_div256(keep_col_p)} + {1'b0, rne_div256(new_col_p)};
    blend_row = {1'b0, rne_div256(keep_row_p)} + {1'b0, rne_div256(new_row_p)};
    center_col_next = (|blend_col[RND_W:hcc_pkg::COORD_W]) ? hcc_pkg::COORD_MAX
                                                          : blend_col[hcc_pkg::COORD_W-1:0];
    center_row_next = (|blend_row[RND_W:hcc_pkg::COORD_W]) ? hcc_pkg::COORD_MAX
                                                          : blend_row[hcc_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hcc_pkg::BK_RUN;
      sum_col     <= '0;
      sum_row     <= '0;
      keyed_count <= '0;
      center_col  <= '0;
      center_row  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        if (q_data.last) begin
          sum_col     <= '0;
          sum_row     <= '0;
          keyed_count <= '0;
        end else begin
          sum_col     <= sum_col_fin;
          sum_row     <= sum_row_fin;
          keyed_count <= cnt_fin;
        end
      end
      if (load_sum) begin
        center_col <= center_col_next;
        center_row <= center_row_next;
      end
      if (load_run || load_sum) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      pend_keyed <= q_data.keyed;
    end
    if (load_run) begin
      out_mask <= q_data.keyed;
      out_col  <= center_col;
      out_row  <= center_row;
      out_done <= q_data.last;
    end else if (load_sum) begin
      out_mask <= pend_keyed;
      out_col  <= center_col_next;
      out_row  <= center_row_next;
      out_done <= 1'b1;
    end
  end

  assign res.valid      = out_valid;
  assign res.mask_on    = out_mask;
  assign res.center_col = out_col;
  assign res.center_row = out_row;
  assign res.frame_done = out_done;

endmodule

// ===== rtl/hsv_color_key_centroid.sv =====
// top level of the hsv colour key with frame centroid tracking
//
// takes one hsv pixel a word with its column and row, keys it when saturation is above
// the threshold and hue falls in the (possibly wrapping) hue window, and returns one
// result word per pixel: the key bit, the kept centre and the frame-end flag. keyed
// coordinates are summed per frame; on the frame's last pixel the centroid (sum over
// count, truncated, clamped to 1023) is blended into the kept centre with weight
// smooth_weight/256, each product rounded half to even, and the sums are cleared.
// ordinary pixels stream through the back end at one a cycle while the output is free.
// the last pixel of a frame with at least one keyed pixel holds the back end while the
// two 30-step restoring dividers (one per axis, run side by side) work, and then in a
// multiply state and a sum state. a four-word queue lets the front end take up to
// four more pixels while it waits. the output register holds each result word until
// it is taken, and the back end waits while it is full and not being read.
// configuration writes are meant for idle periods only
module hsv_color_key_centroid #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [hcc_pkg::WEIGHT_W-1:0]  cfg_data,
  hcc_pix_if.sink                       pix,
  hcc_res_if.source                     res
);

  // configuration registers
  hcc_pkg::key_cfg_t              key_cfg;
  logic [hcc_pkg::WEIGHT_W-1:0]   smooth_weight;

  // queue between front and back end
  logic           q_push;
  logic           q_ready;
  hcc_pkg::pix_t  q_in;
  logic           q_pop;
  logic           q_valid;
  hcc_pkg::pix_t  q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cfg.hue_low       <= hcc_pkg::HUE_LOW_RST;
      key_cfg.hue_high      <= hcc_pkg::HUE_HIGH_RST;
      key_cfg.sat_threshold <= hcc_pkg::SAT_THR_RST;
      smooth_weight         <= hcc_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      case (hcc_pkg::cfg_idx_t'(cfg_index))
        hcc_pkg::CFG_HUE_LOW:  key_cfg.hue_low       <= cfg_data[hcc_pkg::HUE_W-1:0];
        hcc_pkg::CFG_HUE_HIGH: key_cfg.hue_high      <= cfg_data[hcc_pkg::HUE_W-1:0];
        hcc_pkg::CFG_SAT_THR:  key_cfg.sat_threshold <= cfg_data[hcc_pkg::SAT_W-1:0];
        hcc_pkg::CFG_WEIGHT:   smooth_weight         <= cfg_data;
        default: begin
          smooth_weight <= smooth_weight;
        end
      endcase
    end
  end

  // front end: classify and clamp
  hcc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .pix     (pix),
    .cfg     (key_cfg),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  hcc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  // back end: accumulate, divide, blend, output register
  hcc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .smooth_weight (smooth_weight),
    .res           (res)
  );

endmodule

// ===== test/hsv_color_key_centroid_tb.sv =====
// testbench for the hsv colour key with centroid tracking: directed and random pixel streams
`timescale 1ns / 100ps

module hsv_color_key_centroid_tb;

  // a long frame end waits on both dividers; the tail wait and the watchdog leave ample room for it
  localparam int unsigned TAIL_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 150;

  typedef struct packed {
    logic [hcc_pkg::HUE_W-1:0]   hue;
    logic [hcc_pkg::SAT_W-1:0]   saturation;
    logic [hcc_pkg::COORD_W-1:0] col;
    logic [hcc_pkg::COORD_W-1:0] row;
    logic                        frame_last;
  } pixel_word_t;

  typedef struct packed {
    logic                        mask_on;
    logic [hcc_pkg::COORD_W-1:0] center_col;
    logic [hcc_pkg::COORD_W-1:0] center_row;
    logic                        frame_done;
  } result_word_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_we;
  hcc_pkg::cfg_idx_t            cfg_index;
  logic [hcc_pkg::WEIGHT_W-1:0] cfg_data;

  hcc_pix_if pix_ch ();
  hcc_res_if res_ch ();

  hsv_color_key_centroid u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .res       (res_ch)
  );

  // own copy of the key settings and the frame tracking state
  logic [hcc_pkg::HUE_W-1:0]    key_lo;
  logic [hcc_pkg::HUE_W-1:0]    key_hi;
  logic [hcc_pkg::SAT_W-1:0]    sat_thr;
  logic [hcc_pkg::WEIGHT_W-1:0] blend_weight;
  logic [hcc_pkg::SUM_W-1:0]    col_sum;
  logic [hcc_pkg::SUM_W-1:0]    row_sum;
  logic [hcc_pkg::CNT_W-1:0]    keyed_cnt;
  logic [hcc_pkg::COORD_W-1:0]  kept_col;
  logic [hcc_pkg::COORD_W-1:0]  kept_row;

  // result words still owed by the block, oldest first
  result_word_t predicted_words[$];

  int unsigned mismatch_cnt;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          long_hold_req;
  bit          long_hold_done;

  always #6 clk = ~clk;

  // divide by 256, rounding half to even
  function automatic logic [hcc_pkg::COORD_W:0] div256_even(logic [hcc_pkg::PROD_W-1:0] n);
    logic [hcc_pkg::PROD_W-9:0] q;
    q = n[hcc_pkg::PROD_W-1:8];
    if (n[7:0] > 8'd128 || (n[7:0] == 8'd128 && q[0])) q = q + 1'b1;
    return q[hcc_pkg::COORD_W:0];
  endfunction

  // fold the frame mean into the kept centre; weight saturates at one, result at 1023
  function automatic logic [hcc_pkg::COORD_W-1:0] blend_centre(
      logic [hcc_pkg::COORD_W-1:0] kept,
      logic [hcc_pkg::SUM_W-1:0]   sum,
      logic [hcc_pkg::CNT_W-1:0]   cnt);
    logic [hcc_pkg::WEIGHT_W-1:0] w;
    logic [hcc_pkg::SUM_W-1:0]    mean;
    logic [hcc_pkg::COORD_W-1:0]  m;
    logic [hcc_pkg::PROD_W-1:0]   kept_part;
    logic [hcc_pkg::PROD_W-1:0]   mean_part;
    logic [hcc_pkg::COORD_W+1:0]  v;
    w = (blend_weight > hcc_pkg::WEIGHT_ONE) ? hcc_pkg::WEIGHT_ONE : blend_weight;
    mean = sum / hcc_pkg::SUM_W'(cnt);
    m = (mean > hcc_pkg::SUM_W'(hcc_pkg::COORD_MAX)) ? hcc_pkg::COORD_MAX
                                                      : mean[hcc_pkg::COORD_W-1:0];
    kept_part = hcc_pkg::PROD_W'(hcc_pkg::WEIGHT_ONE - w) * hcc_pkg::PROD_W'(kept);
    mean_part = hcc_pkg::PROD_W'(w) * hcc_pkg::PROD_W'(m);
    v = {1'b0, div256_even(kept_part)} + {1'b0, div256_even(mean_part)};
    return (v > (hcc_pkg::COORD_W+2)'(hcc_pkg::COORD_MAX)) ? hcc_pkg::COORD_MAX
                                                          : v[hcc_pkg::COORD_W-1:0];
  endfunction

  // key one pixel, update sums and the centre, and queue the word the block should return
  task automatic key_and_track(pixel_word_t p);
    result_word_t r;
    logic         keyed;
    keyed = 1'b0;
    if (p.saturation > sat_thr) begin
      if (key_lo < key_hi) keyed = (p.hue >= key_lo) && (p.hue <= key_hi);
      else keyed = (p.hue >= key_lo) || (p.hue <= key_hi);   // wrapped window
    end
    // at the default frame size a 10-bit coordinate never reaches the clamp
    if (keyed) begin
      col_sum   = col_sum + hcc_pkg::SUM_W'(p.col);
      row_sum   = row_sum + hcc_pkg::SUM_W'(p.row);
      keyed_cnt = keyed_cnt + 1'b1;
    end
    if (p.frame_last) begin
      // an empty frame keeps the centre but still clears the sums
      if (keyed_cnt != 0) begin
        kept_col = blend_centre(kept_col, col_sum, keyed_cnt);
        kept_row = blend_centre(kept_row, row_sum, keyed_cnt);
      end
      col_sum   = '0;
      row_sum   = '0;
      keyed_cnt = '0;
    end
    r.mask_on    = keyed;
    r.center_col = kept_col;
    r.center_row = kept_row;
    r.frame_done = p.frame_last;
    predicted_words.push_back(r);
  endtask

  function automatic pixel_word_t make_pixel(int unsigned hue, int unsigned sat,
                                             int unsigned col, int unsigned row, bit last);
    pixel_word_t p;
    p.hue        = hue[hcc_pkg::HUE_W-1:0];
    p.saturation = sat[hcc_pkg::SAT_W-1:0];
    p.col        = col[hcc_pkg::COORD_W-1:0];
    p.row        = row[hcc_pkg::COORD_W-1:0];
    p.frame_last = last;
    return p;
  endfunction

  // random pixel, hue often near a window edge and saturation often at or above the threshold
  function automatic pixel_word_t random_pixel(bit last);
    pixel_word_t p;
    int          h;
    case ($urandom_range(0, 3))
      0:       h = int'(key_lo) + int'($urandom_range(0, 2)) - 1;
      1:       h = int'(key_hi) + int'($urandom_range(0, 2)) - 1;
      default: h = int'($urandom_range(0, 179));
    endcase
    if (h < 0) h = 0;
    if (h > 179) h = 179;
    p.hue = h[hcc_pkg::HUE_W-1:0];
    case ($urandom_range(0, 3))
      0:       p.saturation = sat_thr;
      1:       p.saturation = hcc_pkg::SAT_W'($urandom_range(0, 255));
      default: p.saturation = (sat_thr == 8'hFF) ? 8'hFF
                              : hcc_pkg::SAT_W'($urandom_range(sat_thr + 1, 255));
    endcase
    p.col        = hcc_pkg::COORD_W'($urandom_range(0, 1023));
    p.row        = hcc_pkg::COORD_W'($urandom_range(0, 1023));
    p.frame_last = last;
    return p;
  endfunction

  // offer one pixel word, maybe after an idle burst, and hold it until taken
  task automatic send_pixel(pixel_word_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.hue        <= p.hue;
    pix_ch.saturation <= p.saturation;
    pix_ch.col        <= p.col;
    pix_ch.row        <= p.row;
    pix_ch.frame_last <= p.frame_last;
    do @(posedge clk); while (!pix_ch.ready);
    key_and_track(p);
  endtask

  // stop offering and wait until every owed word has come back
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(hcc_pkg::cfg_idx_t idx, logic [hcc_pkg::WEIGHT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      hcc_pkg::CFG_HUE_LOW:  key_lo       = val[hcc_pkg::HUE_W-1:0];
      hcc_pkg::CFG_HUE_HIGH: key_hi       = val[hcc_pkg::HUE_W-1:0];
      hcc_pkg::CFG_SAT_THR:  sat_thr      = val[hcc_pkg::SAT_W-1:0];
      hcc_pkg::CFG_WEIGHT:   blend_weight = val;
      default: ;
    endcase
  endtask

  // new key settings, only once the block has gone idle
  task automatic program_key(int unsigned lo, int unsigned hi, int unsigned thr,
                             int unsigned w);
    drain_results();
    write_reg(hcc_pkg::CFG_HUE_LOW, lo[hcc_pkg::WEIGHT_W-1:0]);
    write_reg(hcc_pkg::CFG_HUE_HIGH, hi[hcc_pkg::WEIGHT_W-1:0]);
    write_reg(hcc_pkg::CFG_SAT_THR, thr[hcc_pkg::WEIGHT_W-1:0]);
    write_reg(hcc_pkg::CFG_WEIGHT, w[hcc_pkg::WEIGHT_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned lo;
    int unsigned hi;
    int unsigned thr;
    int unsigned w;
    case ($urandom_range(0, 5))
      0:       lo = 0;
      1:       lo = 180;
      default: lo = $urandom_range(0, 180);
    endcase
    case ($urandom_range(0, 5))
      0:       hi = 0;
      1:       hi = 180;
      default: hi = $urandom_range(0, 180);
    endcase
    case ($urandom_range(0, 7))
      0:       thr = 0;
      1:       thr = 255;
      default: thr = $urandom_range(0, 200);
    endcase
    case ($urandom_range(0, 4))
      0:       w = 0;
      1:       w = 256;
      default: w = $urandom_range(0, 256);
    endcase
    program_key(lo, hi, thr, w);
  endtask

  // reset values: hue window 180..180 wraps to cover every hue, threshold 127, weight zero
  task automatic test_reset_defaults();
    send_pixel(make_pixel(0, 128, 0, 0, 0));
    send_pixel(make_pixel(179, 127, 5, 5, 0));
    send_pixel(make_pixel(90, 255, 1023, 1023, 1));
  endtask

  // plain window edges, threshold edge, coordinate extremes, then an empty frame
  task automatic test_plain_window();
    program_key(20, 60, 100, 256);
    send_pixel(make_pixel(19, 101, 3, 4, 0));
    send_pixel(make_pixel(20, 101, 0, 0, 0));
    send_pixel(make_pixel(60, 255, 1023, 1023, 0));
    send_pixel(make_pixel(61, 255, 7, 7, 0));
    send_pixel(make_pixel(40, 100, 9, 9, 0));
    send_pixel(make_pixel(40, 0, 11, 11, 1));
    send_pixel(make_pixel(179, 255, 500, 500, 1));
  endtask

  // wrapped window, equal bounds, and the threshold extremes
  task automatic test_wrapped_window();
    program_key(170, 10, 0, 128);
    send_pixel(make_pixel(169, 1, 100, 200, 0));
    send_pixel(make_pixel(170, 1, 300, 400, 0));
    send_pixel(make_pixel(179, 0, 600, 800, 0));
    send_pixel(make_pixel(0, 1, 5, 6, 0));
    send_pixel(make_pixel(11, 200, 1, 2, 1));
    program_key(90, 90, 255, 64);
    send_pixel(make_pixel(90, 255, 700, 300, 0));
    send_pixel(make_pixel(0, 255, 700, 300, 1));
  endtask

  // centre pushed to 1023, a half-way blend that rounds past it, and ties going to even
  task automatic test_centre_limits();
    program_key(0, 180, 0, 256);
    send_pixel(make_pixel(50, 255, 1023, 1023, 1));
    program_key(0, 180, 0, 128);
    send_pixel(make_pixel(50, 255, 1023, 1023, 1));
    send_pixel(make_pixel(50, 255, 1, 2, 1));
  endtask

  // register values beyond their ranges: weight saturates, hue bounds compare as written
  task automatic test_out_of_range_regs();
    program_key(250, 5, 10, 511);
    send_pixel(make_pixel(5, 200, 321, 654, 0));
    send_pixel(make_pixel(6, 200, 1, 1, 1));
    program_key(0, 200, 10, 300);
    send_pixel(make_pixel(179, 200, 77, 88, 1));
  endtask

  // random settings per phase, short frames of random pixels
  task automatic test_random_frames();
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      for (int n = 0; n < 70; n++) send_pixel(random_pixel(n == 69 || $urandom_range(0, 9) == 0));
    end
  endtask

  // receiver holds off for a long time while pixels keep coming, so the input stalls
  task automatic test_output_backpressure();
    program_key(30, 150, 60, 200);
    long_hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_pixel(random_pixel(n % 8 == 7));
  endtask

  // back-to-back words on both sides to finish
  task automatic test_steady_stream();
    random_config();
    idle_on = 1'b0;
    for (int n = 0; n < 100; n++) send_pixel(random_pixel(n == 99 || $urandom_range(0, 7) == 0));
  endtask

  // result side: compare each accepted word, then decide ready for the next edge
  task automatic check_result();
    result_word_t want;
    if (predicted_words.size() == 0) begin
      $display("%0t: result word with none owed: mask %0d col %0d row %0d done %0d", $time,
               res_ch.mask_on, res_ch.center_col, res_ch.center_row, res_ch.frame_done);
      mismatch_cnt++;
    end else begin
      want = predicted_words.pop_front();
      if (res_ch.mask_on !== want.mask_on) begin
        $display("%0t: mask_on expected %0d actual %0d", $time, want.mask_on, res_ch.mask_on);
        mismatch_cnt++;
      end
      if (res_ch.center_col !== want.center_col) begin
        $display("%0t: center_col expected %0d actual %0d", $time, want.center_col,
                 res_ch.center_col);
        mismatch_cnt++;
      end
      if (res_ch.center_row !== want.center_row) begin
        $display("%0t: center_row expected %0d actual %0d", $time, want.center_row,
                 res_ch.center_row);
        mismatch_cnt++;
      end
      if (res_ch.frame_done !== want.frame_done) begin
        $display("%0t: frame_done expected %0d actual %0d", $time, want.frame_done,
                 res_ch.frame_done);
        mismatch_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result();
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (long_hold_req && !long_hold_done) begin
        res_ch.ready <= 1'b0;
        hold_left = LONG_HOLD - 1;
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        hold_left = $urandom_range(0, 5);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any word or register write moving means a hang
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = hcc_pkg::CFG_HUE_LOW;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.hue         = '0;
    pix_ch.saturation  = '0;
    pix_ch.col         = '0;
    pix_ch.row         = '0;
    pix_ch.frame_last  = 1'b0;
    idle_on            = 1'b1;
    long_hold_req      = 1'b0;
    // predictor starts from the reset values of the block
    key_lo       = hcc_pkg::HUE_LOW_RST;
    key_hi       = hcc_pkg::HUE_HIGH_RST;
    sat_thr      = hcc_pkg::SAT_THR_RST;
    blend_weight = hcc_pkg::WEIGHT_RST;
    col_sum      = '0;
    row_sum      = '0;
    keyed_cnt    = '0;
    kept_col     = '0;
    kept_row     = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_plain_window();
    test_wrapped_window();
    test_centre_limits();
    test_out_of_range_regs();
    test_random_frames();
    test_output_backpressure();
    test_steady_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && predicted_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (predicted_words.size() != 0)
        $display("%0t: %0d result words never arrived", $time, predicted_words.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== hsv_color_key_centroid.f =====
rtl/hcc_pkg.sv
rtl/hcc_ifs.sv
rtl/hcc_front.sv
rtl/hcc_fifo.sv
rtl/hcc_div.sv
rtl/hcc_back.sv
rtl/hsv_color_key_centroid.sv
test/hsv_color_key_centroid_tb.sv
